>>> rtl/core/brb_pkg.sv
// Package for the circular byte FIFO: field types, operation codes and
// fixed constants. It depends on nothing else.
`default_nettype none

package brb_pkg;

    // Field widths fixed by the interface.
    localparam int BYTE_W = 8;
    localparam int AMT_W  = 11;
    localparam int REQ_W  = 7;
    localparam int FUNC_W = 3;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [AMT_W-1:0]  t_amount;
    typedef logic [REQ_W-1:0]  t_req;
    typedef logic [FUNC_W-1:0] t_func;

    // Operation codes.
    localparam t_func FUNC_WRITE = 3'd0;
    localparam t_func FUNC_READ  = 3'd1;
    localparam t_func FUNC_PEEK  = 3'd2;
    localparam t_func FUNC_SKIP  = 3'd3;
    localparam t_func FUNC_CLEAR = 3'd4;

    // Saturation value of the write run counter and reset capacity.
    localparam t_amount RUN_MAX   = 11'd2047;
    localparam t_amount CAP_RESET = 11'd1024;

endpackage : brb_pkg

`default_nettype wire

>>> rtl/core/brb_store.sv
// Byte storage of the circular FIFO: one write port and one registered read
// port. Uses brb_pkg for the byte type.
`default_nettype none

module brb_store
    import brb_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int PW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [PW-1:0] i_waddr,
    input  t_byte         i_wdata,
    input  logic          i_re,
    input  logic [PW-1:0] i_raddr,
    output t_byte         o_rdata
);

    t_byte r_mem [DEPTH];
    t_byte r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : brb_store

`default_nettype wire

>>> rtl/core/brb_advance.sv
// Shared pointer step unit: increments a ring pointer and wraps it at the
// capacity in use. Uses brb_pkg for the capacity type.
`default_nettype none

module brb_advance
    import brb_pkg::*;
#(
    parameter int PW = 10
) (
    input  logic [PW-1:0] i_ptr,
    input  t_amount       i_cap,
    output logic [PW-1:0] o_ptr
);

    localparam int AW = (PW + 1 > AMT_W) ? PW + 1 : AMT_W;

    logic [AW-1:0] w_next;

    // One add and one compare against the capacity.
    assign w_next = AW'(i_ptr) + AW'(1);
    assign o_ptr  = (w_next >= AW'(i_cap)) ? '0 : w_next[PW-1:0];

endmodule : brb_advance

`default_nettype wire

>>> rtl/core/byte_ring_buffer_top.sv
// Top level of the circular byte FIFO: sequencer, pointers, fill count and
// configuration. Uses brb_pkg, brb_store and brb_advance.
`default_nettype none

// Usage:
// An operation is taken when start is high and busy is low. Its results
// appear on o_out_byte, o_amount and o_last for one cycle each, marked by
// o_strobe; the receiver cannot hold them off, so no result is ever held back.
// During a write byte busy stays low, so writes stream at one byte per cycle;
// the last byte of a run gives its result the next cycle.
// Read and peek of n available bytes keep busy high while the bytes are read
// and emit one byte per cycle, the first behind the state register and the
// store's read register, since the byte store has a registered read port.
// Skip of n bytes keeps busy high while stepping and reports in the cycle after the last.
// Clear, requests with nothing available or a zero length, and a zero
// capacity answer in the cycle after the transfer with busy low. The rate of
// read, peek and skip is set by the one pointer step unit, used once per
// cycle, and the single read port of the byte store.
// The capacity register is written over its own channel while the block is
// idle; a write empties the buffer. Reset empties the buffer, clears the
// run count and sets the capacity to 1024 (clamped to DEPTH).
module byte_ring_buffer_top
    import brb_pkg::*;
#(
    parameter int DEPTH       = 1024,
    parameter int MAX_REQUEST = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_func   i_func,
    input  t_byte   i_data_byte,
    input  logic    i_write_last,
    input  t_req    i_request_length,
    output logic    o_strobe,
    output t_byte   o_out_byte,
    output t_amount o_amount,
    output logic    o_last,
    input  logic    i_cfg_valid,
    output logic    o_cfg_ready,
    input  t_amount i_cfg_data
);

    localparam int   PW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int   CW      = (PW + 1 > AMT_W) ? PW + 1 : AMT_W;
    localparam t_req REQ_MAX = REQ_W'(MAX_REQUEST);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;

    // Capacity in use, limited to the store depth.
    function automatic t_amount clamp_cap(input t_amount v);
        if (CW'(v) > CW'(DEPTH)) begin
            return AMT_W'(DEPTH);
        end
        return v;
    endfunction

    logic [1:0]    r_state, n_state;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    t_amount       r_fill, n_fill;
    t_amount       r_run, n_run;
    t_amount       r_cap_eff, n_cap_eff;
    logic          r_strobe, n_strobe;
    logic [PW-1:0] r_walk, n_walk;
    t_req          r_left, n_left;
    t_req          r_total, n_total;
    logic          r_consume, n_consume;
    t_amount       r_amount, n_amount;
    logic          r_last, n_last;
    logic          r_osel, n_osel;

    logic          w_accept;
    logic          w_cfg_wr;
    t_req          w_req_sat;
    t_req          w_avail;
    logic          w_room;
    t_amount       w_run_inc;
    logic [PW-1:0] w_adv_in;
    logic [PW-1:0] w_adv_out;
    logic          w_mem_we;
    t_byte         w_rdata;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign w_accept    = start & ~busy;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;

    // Request limit and the number of bytes that can be served.
    assign w_req_sat = (i_request_length > REQ_MAX) ? REQ_MAX : i_request_length;
    assign w_avail   = (r_cap_eff == '0) ? '0 :
                       ((AMT_W'(w_req_sat) < r_fill) ? w_req_sat : r_fill[REQ_W-1:0]);
    assign w_room    = (r_cap_eff != '0) && (r_fill < r_cap_eff);
    assign w_run_inc = (w_room && (r_run != RUN_MAX)) ? r_run + AMT_W'(1) : r_run;

    // The step unit serves the write pointer when idle, the walk otherwise.
    assign w_adv_in = (r_state == ST_IDLE) ? r_wr_ptr : r_walk;

    brb_advance #(
        .PW (PW)
    ) u_advance (
        .i_ptr (w_adv_in),
        .i_cap (r_cap_eff),
        .o_ptr (w_adv_out)
    );

    brb_store #(
        .DEPTH (DEPTH),
        .PW    (PW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_data_byte),
        .i_re    (r_state == ST_READ),
        .i_raddr (r_walk),
        .o_rdata (w_rdata)
    );

    // Sequencer and pointer updates.
    always_comb begin
        n_state   = r_state;
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_fill    = r_fill;
        n_run     = r_run;
        n_cap_eff = r_cap_eff;
        n_walk    = r_walk;
        n_left    = r_left;
        n_total   = r_total;
        n_consume = r_consume;
        n_strobe  = 1'b0;
        n_amount  = '0;
        n_last    = 1'b0;
        n_osel    = 1'b0;
        w_mem_we  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_func) inside
                        FUNC_WRITE: begin
                            if (w_room) begin
                                w_mem_we = 1'b1;
                                n_wr_ptr = w_adv_out;
                                n_fill   = r_fill + AMT_W'(1);
                            end
                            n_run = w_run_inc;
                            if (i_write_last) begin
                                n_strobe = 1'b1;
                                n_amount = w_run_inc;
                                n_last   = 1'b1;
                                n_run    = '0;
                            end
                        end
                        FUNC_READ, FUNC_PEEK, FUNC_SKIP: begin
                            if (w_avail == '0) begin
                                n_strobe = 1'b1;
                                n_last   = 1'b1;
                            end else begin
                                n_state   = (i_func == FUNC_SKIP) ? ST_SKIP : ST_READ;
                                n_walk    = r_rd_ptr;
                                n_left    = w_avail;
                                n_total   = w_avail;
                                n_consume = (i_func == FUNC_READ);
                            end
                        end
                        FUNC_CLEAR: begin
                            n_rd_ptr = '0;
                            n_wr_ptr = '0;
                            n_fill   = '0;
                            n_strobe = 1'b1;
                            n_last   = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                // One byte leaves per cycle, read at the walking pointer.
                n_walk   = w_adv_out;
                n_left   = r_left - REQ_W'(1);
                n_strobe = 1'b1;
                n_osel   = 1'b1;
                n_amount = AMT_W'(r_total);
                n_last   = (r_left == REQ_W'(1));
                if (r_left == REQ_W'(1)) begin
                    n_state = ST_IDLE;
                    if (r_consume) begin
                        n_rd_ptr = w_adv_out;
                        n_fill   = r_fill - AMT_W'(r_total);
                    end
                end
            end
            ST_SKIP: begin
                // Step over one byte per cycle, report at the end.
                n_walk = w_adv_out;
                n_left = r_left - REQ_W'(1);
                if (r_left == REQ_W'(1)) begin
                    n_state  = ST_IDLE;
                    n_rd_ptr = w_adv_out;
                    n_fill   = r_fill - AMT_W'(r_total);
                    n_strobe = 1'b1;
                    n_amount = AMT_W'(r_total);
                    n_last   = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // A capacity write empties the buffer and ends any write run.
        if (w_cfg_wr) begin
            n_cap_eff = clamp_cap(i_cfg_data);
            n_rd_ptr  = '0;
            n_wr_ptr  = '0;
            n_fill    = '0;
            n_run     = '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_fill    <= '0;
            r_run     <= '0;
            r_cap_eff <= clamp_cap(CAP_RESET);
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_ptr  <= n_rd_ptr;
            r_wr_ptr  <= n_wr_ptr;
            r_fill    <= n_fill;
            r_run     <= n_run;
            r_cap_eff <= n_cap_eff;
            r_strobe  <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_walk    <= n_walk;
        r_left    <= n_left;
        r_total   <= n_total;
        r_consume <= n_consume;
        r_amount  <= n_amount;
        r_last    <= n_last;
        r_osel    <= n_osel;
    end

    // Result ports; the byte comes straight from the store's read register.
    assign o_strobe   = r_strobe;
    assign o_amount   = r_amount;
    assign o_last     = r_last;
    assign o_out_byte = r_osel ? w_rdata : '0;

`ifndef SYNTHESIS
    // The fill count never exceeds the capacity in use.
    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_cap_eff)
        else $error("fill count above capacity");

    // Both pointers stay inside the ring.
    a_wr_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr == '0) || (CW'(r_wr_ptr) < CW'(r_cap_eff)))
        else $error("write pointer outside ring");

    a_rd_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_ptr == '0) || (CW'(r_rd_ptr) < CW'(r_cap_eff)))
        else $error("read pointer outside ring");

    // A busy sequencer always has bytes left to handle.
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_left != '0))
        else $error("busy with no bytes left");

    // The final skip step reports with the last mark.
    a_skip_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SKIP && r_left == REQ_W'(1)) |=> (o_strobe && o_last))
        else $error("skip ended without a result");
`endif

endmodule : byte_ring_buffer_top

`default_nettype wire

>>> tb/sv/byte_ring_buffer_top_test.sv
// Self-checking testbench for byte_ring_buffer_top, the circular byte FIFO.
// Depends on brb_pkg and the RTL only; a small board class predicts every reply
// from its own copy of the FIFO state and checks the replies in order.
`default_nettype none

module byte_ring_buffer_top_test;
    import brb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIFO_DEPTH    = 1024;
    localparam int MAX_REQ       = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_OPS     = 38;

    // Operation codes the block does not know; it must ignore them.
    localparam t_func FUNC_SPARE_FIRST = 3'd5;
    localparam t_func FUNC_SPARE_LAST  = 3'd7;

    typedef struct {
        t_byte   data;
        t_amount amount;
        logic    last;
    } t_fifo_reply;

    // Tracks the FIFO contents and the replies still owed by the block.
    class fifo_reply_board;
        t_byte       store [FIFO_DEPTH];
        int unsigned rd_ptr;
        int unsigned wr_ptr;
        int unsigned fill;
        int unsigned run_len;
        int unsigned capacity;
        int unsigned mismatches;
        t_fifo_reply replies_due [$];

        function new();
            capacity   = CAP_RESET;
            rd_ptr     = 0;
            wr_ptr     = 0;
            fill       = 0;
            run_len    = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return replies_due.size();
        endfunction

        function int unsigned wrap_step(int unsigned p, int unsigned cap);
            return (p + 1 >= cap) ? 0 : p + 1;
        endfunction

        function void add_reply(t_byte data, int unsigned amount, logic last);
            t_fifo_reply r;
            r.data   = data;
            r.amount = t_amount'(amount);
            r.last   = last;
            replies_due.push_back(r);
        endfunction

        // A capacity write empties the buffer and ends any write run.
        function void set_capacity(t_amount value);
            capacity = value;
            rd_ptr   = 0;
            wr_ptr   = 0;
            fill     = 0;
            run_len  = 0;
        endfunction

        // Called for every accepted operation transfer.
        function void note_op(t_func op, t_byte data, logic wlast, t_req req);
            int unsigned cap;
            int unsigned len;
            int unsigned n;
            int unsigned p;
            cap = (capacity > FIFO_DEPTH) ? FIFO_DEPTH : capacity;
            len = (req > MAX_REQ) ? MAX_REQ : req;
            n   = (cap == 0) ? 0 : ((len < fill) ? len : fill);
            case (op) inside
                FUNC_WRITE: begin
                    if (cap != 0 && fill < cap) begin
                        store[wr_ptr] = data;
                        wr_ptr = wrap_step(wr_ptr, cap);
                        fill++;
                        if (run_len < RUN_MAX) run_len++;
                    end
                    if (wlast) begin
                        add_reply('0, run_len, 1'b1);
                        run_len = 0;
                    end
                end
                FUNC_READ, FUNC_PEEK: begin
                    if (n == 0) add_reply('0, 0, 1'b1);
                    p = rd_ptr;
                    for (int i = 0; i < n; i++) begin
                        add_reply(store[p], n, (i + 1 == n));
                        p = wrap_step(p, cap);
                    end
                    if (op == FUNC_READ) begin
                        rd_ptr = p;
                        fill  -= n;
                    end
                end
                FUNC_SKIP: begin
                    for (int i = 0; i < n; i++) rd_ptr = wrap_step(rd_ptr, cap);
                    fill -= n;
                    add_reply('0, n, 1'b1);
                end
                FUNC_CLEAR: begin
                    rd_ptr = 0;
                    wr_ptr = 0;
                    fill   = 0;
                    add_reply('0, 0, 1'b1);
                end
                default: ;
            endcase
        endfunction

        // Called for every strobed reply; compares it with the oldest one owed.
        function void check_reply(t_byte data, t_amount amount, logic last);
            t_fifo_reply due;
            if (replies_due.size() == 0) begin
                $display({"%0t: reply with none due: expected none, ",
                          "actual byte %0d amount %0d last %0b"},
                         $time, data, amount, last);
                mismatches++;
                return;
            end
            due = replies_due.pop_front();
            if (data !== due.data) begin
                $display("%0t: out_byte mismatch: expected %0d, actual %0d",
                         $time, due.data, data);
                mismatches++;
            end
            if (amount !== due.amount) begin
                $display("%0t: amount mismatch: expected %0d, actual %0d",
                         $time, due.amount, amount);
                mismatches++;
            end
            if (last !== due.last) begin
                $display("%0t: last mismatch: expected %0b, actual %0b",
                         $time, due.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic    i_clk            = 1'b0;
    logic    i_rst_n          = 1'b0;
    logic    start            = 1'b0;
    logic    busy;
    t_func   i_func           = FUNC_WRITE;
    t_byte   i_data_byte      = '0;
    logic    i_write_last     = 1'b0;
    t_req    i_request_length = '0;
    logic    o_strobe;
    t_byte   o_out_byte;
    t_amount o_amount;
    logic    o_last;
    logic    i_cfg_valid      = 1'b0;
    logic    o_cfg_ready;
    t_amount i_cfg_data       = '0;

    fifo_reply_board board;
    bit              burst_mode = 1'b0;

    byte_ring_buffer_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_data_byte      (i_data_byte),
        .i_write_last     (i_write_last),
        .i_request_length (i_request_length),
        .o_strobe         (o_strobe),
        .o_out_byte       (o_out_byte),
        .o_amount         (o_amount),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Observe transfers and replies at the rising edge, using pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe === 1'b1) board.check_reply(o_out_byte, o_amount, o_last);
            if (start && busy === 1'b0)
                board.note_op(i_func, i_data_byte, i_write_last, i_request_length);
            if (i_cfg_valid && o_cfg_ready === 1'b1) board.set_capacity(i_cfg_data);
        end
    end

    // Present one operation after a random gap (none in burst mode) and hold it until the transfer.
    task automatic issue_op(input t_func op, input t_byte data, input logic wlast,
                            input t_req req);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start            <= 1'b1;
        i_func           <= op;
        i_data_byte      <= data;
        i_write_last     <= wlast;
        i_request_length <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Stop sending and wait until every owed reply has arrived.
    task automatic wait_replies_done();
        @(negedge i_clk);
        start <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_capacity(input t_amount value);
        wait_replies_done();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Short write runs mixed with reads, peeks, skips and clears; ignored codes do not count.
    task automatic run_random_ops(input int unsigned count);
        int unsigned done_ops;
        int unsigned pick;
        t_func       op;
        t_req        req;
        done_ops = 0;
        while (done_ops < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      op = FUNC_WRITE;
            else if (pick < 65) op = FUNC_READ;
            else if (pick < 75) op = FUNC_PEEK;
            else if (pick < 87) op = FUNC_SKIP;
            else if (pick < 92) op = FUNC_CLEAR;
            else op = t_func'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
            case ($urandom_range(0, 9))
                0:       req = '0;
                1:       req = t_req'(MAX_REQ);
                2:       req = t_req'($urandom_range(MAX_REQ + 1, 127));
                default: req = t_req'($urandom_range(1, 12));
            endcase
            issue_op(op, t_byte'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0), req);
            if (op <= FUNC_CLEAR) done_ops++;
            if ($urandom_range(0, 29) == 0) wait_replies_done();
        end
    endtask

    // Ends the run when no transfer of any kind happens for too long.
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && busy === 1'b0) || o_strobe === 1'b1
                    || (i_cfg_valid && o_cfg_ready === 1'b1))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("byte_ring_buffer_top_test NOT OK");
        $finish;
    end

    initial begin : stimulus
        t_amount cap_plan [8];
        cap_plan = '{11'd17, 11'd0, 11'd2047, 11'd1, 11'd3, 11'd1024,
                     11'd200, 11'd64};
        board = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset capacity.
        // Read, peek and skip on an empty buffer, including a zero request.
        issue_op(FUNC_READ, 8'h00, 1'b0, 7'd5);
        issue_op(FUNC_PEEK, 8'hFF, 1'b1, 7'd0);
        issue_op(FUNC_SKIP, 8'h00, 1'b0, 7'd3);
        // A three-byte run with extreme data values.
        issue_op(FUNC_WRITE, 8'h00, 1'b0, 7'd0);
        issue_op(FUNC_WRITE, 8'hFF, 1'b0, 7'h7F);
        issue_op(FUNC_WRITE, 8'hA5, 1'b1, 7'd0);
        issue_op(FUNC_READ, 8'h00, 1'b0, 7'd0);
        issue_op(FUNC_PEEK, 8'h00, 1'b0, 7'd2);
        // Unknown codes must produce nothing.
        for (int k = FUNC_SPARE_FIRST; k <= FUNC_SPARE_LAST; k++)
            issue_op(t_func'(k), 8'h3C, 1'b1, 7'd9);
        // Other operations inside a write run do not end it.
        issue_op(FUNC_WRITE, 8'h11, 1'b0, 7'd0);
        issue_op(FUNC_PEEK, 8'h00, 1'b0, 7'd1);
        issue_op(FUNC_WRITE, 8'h22, 1'b1, 7'd0);
        issue_op(FUNC_SKIP, 8'h00, 1'b0, 7'd1);
        // Oversized request saturates and drains what is left.
        issue_op(FUNC_READ, 8'h00, 1'b0, 7'd127);
        issue_op(FUNC_WRITE, 8'h7E, 1'b1, 7'd0);
        // Clear keeps the run count going.
        issue_op(FUNC_WRITE, 8'h01, 1'b0, 7'd0);
        issue_op(FUNC_CLEAR, 8'h00, 1'b0, 7'd0);
        issue_op(FUNC_WRITE, 8'h02, 1'b1, 7'd0);
        issue_op(FUNC_SKIP, 8'h00, 1'b0, 7'd100);
        issue_op(FUNC_CLEAR, 8'h00, 1'b0, 7'd0);

        // Random phases across several capacities, extremes included.
        foreach (cap_plan[c]) begin
            write_capacity(cap_plan[c]);
            burst_mode = ($urandom_range(0, 2) == 0);
            run_random_ops(PHASE_OPS);
        end

        wait_replies_done();
        if (board.mismatches == 0 && board.pending() == 0)
            $display("byte_ring_buffer_top_test OK");
        else
            $display("byte_ring_buffer_top_test NOT OK");
        $finish;
    end

endmodule : byte_ring_buffer_top_test

`default_nettype wire
